[design/assert_macros.svh]
// Assertion macros shared by the grid point sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on i_clk and disabled during reset.
`define TBGP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled during reset.
`define TBGP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tbgp_pkg.sv]
// Shared constants and types of the barycentric grid point sampler.
package tbgp_pkg;

    // Coordinate and grid index widths.
    localparam int COORD_W = 32;
    localparam int IDX_W   = 4;

    // Default number of grid divisions per triangle edge.
    localparam int GRID_DIVISIONS_DEF = 8;

    // Most points emitted for one triangle, and the width of their count.
    localparam int MAX_POINTS = 42;
    localparam int CNT_W      = $clog2(MAX_POINTS);

    // Register stages between point issue and the output register, inclusive.
    localparam int PIPE_DEPTH = 6;

    // Barycentric weights of one grid point, in units of 1/N.
    typedef struct packed {
        logic [IDX_W-1:0] wa;
        logic [IDX_W-1:0] wi;
        logic [IDX_W-1:0] wj;
    } t_step;

    // Side information that travels with a point through the pipeline.
    typedef struct packed {
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic             last;
    } t_meta;

endpackage

[design/triangle_barycentric_grid_points.sv]
// Top level of the barycentric grid point sampler: point sequencer and pipeline control.
//
//  Channel  Dir  Handshake             Payload
//  s        in   i_s_tvalid/o_s_tready  i_s_tdata: one triangle, three vertices
//  m        out  o_m_tvalid/i_m_tready  o_m_tdata: one grid point, o_m_tlast ends run
//
// One triangle yields (N+1)(N+2)/2-3 points, capped at 42, one point per cycle while
// the output is not stalled; the point sequencer sets this rate.
// A point is registered in each blend stage, the last of which is the output register.
// The next triangle is taken while the last point of the current one is issued,
// or at any time while the sequencer is idle, also during an output stall.
// An output stall freezes the whole pipeline; reset clears only valid and busy bits.
`include "assert_macros.svh"

module triangle_barycentric_grid_points #(
    parameter int GRID_DIVISIONS = tbgp_pkg::GRID_DIVISIONS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
    input  logic [287:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // point_x, point_y, point_z, step_along_second, step_along_third
    output logic [103:0] o_m_tdata,
    output logic         o_m_tlast
);

    localparam int CW    = tbgp_pkg::COORD_W;
    localparam int IW    = tbgp_pkg::IDX_W;
    localparam int CNTW  = tbgp_pkg::CNT_W;
    localparam int DEPTH = tbgp_pkg::PIPE_DEPTH;
    localparam logic [IW-1:0]   N_IDX    = IW'(GRID_DIVISIONS);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(tbgp_pkg::MAX_POINTS - 1);

    // Pipeline advance: everything moves unless the output holds an untaken point.
    logic w_adv;
    logic w_s_acc;
    logic w_issue;
    logic w_is_last;

    // Sequencer state: current triangle and the grid point about to be issued.
    logic                 r_busy;
    logic [IW-1:0]        r_i;
    logic [IW-1:0]        r_j;
    logic [CNTW-1:0]      r_cnt;
    logic signed [CW-1:0] r_vtx [9];
    logic [IW-1:0]        n_i;
    logic [IW-1:0]        n_j;

    assign w_adv     = !o_m_tvalid || i_m_tready;
    assign w_issue   = r_busy && w_adv;
    assign w_is_last = (r_i == N_IDX - IW'(1) && r_j == IW'(1)) || (r_cnt == CNT_LAST);
    assign o_s_tready = !r_busy || (w_adv && w_is_last);
    assign w_s_acc   = i_s_tvalid && o_s_tready;

    // Next grid point in loop order, stepping over the corners.
    always_comb begin
        priority if (r_i == '0 && r_j == N_IDX - IW'(1)) begin
            n_i = IW'(1);
            n_j = '0;
        end else if (r_j == N_IDX - r_i) begin
            n_i = r_i + IW'(1);
            n_j = '0;
        end else begin
            n_i = r_i;
            n_j = r_j + IW'(1);
        end
    end

    // Sequencer control; a new transaction takes over from the last issued point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_j    <= IW'(1);
                r_cnt  <= '0;
            end else if (w_issue) begin
                r_i   <= n_i;
                r_j   <= n_j;
                r_cnt <= r_cnt + CNTW'(1);
                if (w_is_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Vertex registers, loaded on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            for (int k = 0; k < 9; k++) begin
                r_vtx[k] <= i_s_tdata[k*CW +: CW];
            end
        end
    end

    // Weights of the issued point.
    tbgp_pkg::t_step w_step;

    assign w_step.wa = N_IDX - r_i - r_j;
    assign w_step.wi = r_i;
    assign w_step.wj = r_j;

    // Valid bits and grid indices travel alongside the arithmetic stages.
    logic            r_vld  [DEPTH];
    tbgp_pkg::t_meta r_meta [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= w_issue;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_meta[0].i    <= r_i;
            r_meta[0].j    <= r_j;
            r_meta[0].last <= w_is_last;
            for (int k = 1; k < DEPTH; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // One blend pipeline per coordinate.
    logic [CW-1:0] w_pt [3];

    for (genvar c = 0; c < 3; c++) begin : g_coord
        tbgp_blend #(
            .GRID_DIVISIONS(GRID_DIVISIONS)
        ) u_blend (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_a    (r_vtx[c]),
            .i_b    (r_vtx[3 + c]),
            .i_c    (r_vtx[6 + c]),
            .i_step (w_step),
            .o_point(w_pt[c])
        );
    end

    // Output channel.
    assign o_m_tvalid = r_vld[DEPTH-1];
    assign o_m_tlast  = r_meta[DEPTH-1].last;
    assign o_m_tdata  = {r_meta[DEPTH-1].j, r_meta[DEPTH-1].i, w_pt[2], w_pt[1], w_pt[0]};

    // A new triangle always starts at the first point after the origin corner.
    `TBGP_ASSERT_NXT(a_start_point, w_s_acc,
        r_busy && r_i == '0 && r_j == IW'(1) && r_cnt == '0,
        "sequencer did not restart at the first grid point")

    // The issued point lies on the grid and is never a corner.
    `TBGP_ASSERT_IMP(a_point_on_grid, r_busy,
        ((IW+1)'(r_i) + (IW+1)'(r_j) <= (IW+1)'(N_IDX)) &&
        !(r_i == '0 && r_j == '0) && !(r_i == '0 && r_j == N_IDX) &&
        !(r_i == N_IDX && r_j == '0),
        "issued grid point is off the grid or a corner")

    // The point count never passes the per-triangle limit.
    `TBGP_ASSERT_IMP(a_count_bound, r_busy, r_cnt <= CNT_LAST,
        "point count exceeded the per-triangle limit")

endmodule

[design/tbgp_blend.sv]
// Pipelined weighted blend of one coordinate, divided by N with rounding and saturation.
module tbgp_blend #(
    parameter int GRID_DIVISIONS = tbgp_pkg::GRID_DIVISIONS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [tbgp_pkg::COORD_W-1:0] i_a,
    input  logic signed [tbgp_pkg::COORD_W-1:0] i_b,
    input  logic signed [tbgp_pkg::COORD_W-1:0] i_c,
    input  tbgp_pkg::t_step                    i_step,
    output logic        [tbgp_pkg::COORD_W-1:0] o_point
);

    localparam int CW     = tbgp_pkg::COORD_W;
    localparam int PROD_W = CW + tbgp_pkg::IDX_W + 1;
    localparam int SUMX_W = PROD_W + 2;
    // Rounded magnitude stays below 2^MAG_W, which is also the reciprocal scale.
    localparam int MAG_W  = CW + $clog2(GRID_DIVISIONS);
    localparam int LO_W   = MAG_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PH_W   = HI_W + MAG_W;
    localparam int PL_W   = LO_W + MAG_W;
    localparam int TOT_W  = 2 * MAG_W + 1;

    localparam logic [MAG_W-1:0] RECIP =
        MAG_W'((64'd1 << MAG_W) / 64'(GRID_DIVISIONS));
    localparam logic [MAG_W-1:0] NDIV    = MAG_W'(GRID_DIVISIONS);
    localparam logic [MAG_W-1:0] HALF    = MAG_W'(GRID_DIVISIONS / 2);
    localparam logic [MAG_W-1:0] POS_MAX = (MAG_W'(1) << (CW - 1)) - MAG_W'(1);
    localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(1) << (CW - 1);

    // Stage 1: the three weighted products.
    logic signed [PROD_W-1:0] w_pa, w_pb, w_pc;
    logic signed [PROD_W-1:0] r_pa, r_pb, r_pc;

    assign w_pa = PROD_W'($signed({1'b0, i_step.wa})) * PROD_W'(i_a);
    assign w_pb = PROD_W'($signed({1'b0, i_step.wi})) * PROD_W'(i_b);
    assign w_pc = PROD_W'($signed({1'b0, i_step.wj})) * PROD_W'(i_c);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= w_pa;
            r_pb <= w_pb;
            r_pc <= w_pc;
        end
    end

    // Stage 2: signed sum, then magnitude plus half a divisor for rounding.
    logic signed [SUMX_W-1:0] w_sum;
    logic        [SUMX_W-1:0] w_abs;
    logic                     w_neg;
    logic        [MAG_W-1:0]  r_x2;
    logic                     r_neg2;

    assign w_sum = SUMX_W'(r_pa) + SUMX_W'(r_pb) + SUMX_W'(r_pc);
    assign w_neg = w_sum[SUMX_W-1];
    assign w_abs = w_neg ? SUMX_W'(-w_sum) : SUMX_W'(w_sum);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2   <= MAG_W'(w_abs) + HALF;
            r_neg2 <= w_neg;
        end
    end

    // Stage 3: reciprocal multiply, split into two partial products.
    logic [HI_W-1:0]  w_xh;
    logic [LO_W-1:0]  w_xl;
    logic [PH_W-1:0]  r_ph;
    logic [PL_W-1:0]  r_pl;
    logic [MAG_W-1:0] r_x3;
    logic             r_neg3;

    assign w_xh = r_x2[MAG_W-1:LO_W];
    assign w_xl = r_x2[LO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph   <= PH_W'(w_xh) * PH_W'(RECIP);
            r_pl   <= PL_W'(w_xl) * PL_W'(RECIP);
            r_x3   <= r_x2;
            r_neg3 <= r_neg2;
        end
    end

    // Stage 4: combine the partial products into a quotient estimate.
    // The estimate is the true quotient or one below it.
    logic [TOT_W-1:0] w_tot;
    logic [MAG_W-1:0] r_q4;
    logic [MAG_W-1:0] r_x4;
    logic             r_neg4;

    assign w_tot = (TOT_W'(r_ph) << LO_W) + TOT_W'(r_pl);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q4   <= w_tot[MAG_W +: MAG_W];
            r_x4   <= r_x3;
            r_neg4 <= r_neg3;
        end
    end

    // Stage 5: correct the estimate by one where the remainder reaches N.
    logic [MAG_W-1:0] w_qn;
    logic [MAG_W-1:0] w_rem;
    logic [MAG_W-1:0] r_q5;
    logic             r_neg5;

    assign w_qn  = r_q4 * NDIV;
    assign w_rem = r_x4 - w_qn;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q5   <= (w_rem >= NDIV) ? r_q4 + MAG_W'(1) : r_q4;
            r_neg5 <= r_neg4;
        end
    end

    // Stage 6: restore the sign and clamp to the 32-bit range.
    logic [CW-1:0] w_res;
    logic [CW-1:0] r_point;

    always_comb begin
        if (r_neg5) begin
            w_res = (r_q5 > NEG_MAX) ? NEG_MAX[CW-1:0] : CW'(-r_q5[CW-1:0]);
        end else begin
            w_res = (r_q5 > POS_MAX) ? POS_MAX[CW-1:0] : r_q5[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_point <= w_res;
        end
    end

    assign o_point = r_point;

endmodule
